FILE: hw/rtl/sclt_pkg.sv
// Shared types, character constants and the control program of the line tokenizer.
// Depends on nothing; imported by serial_command_line_tokenizer_unit.
package sclt_pkg;

	localparam int CHAR_W  = 8;
	localparam int ARG_W   = 16;
	localparam int COUNT_W = 7;
	localparam int KIND_W  = 2;
	localparam int PC_W    = 3;

	localparam logic [CHAR_W-1:0] END_CHAR_RESET = 8'h3B; // ';'
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
	localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

	localparam logic [KIND_W-1:0] KIND_NAME  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ARG   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_COUNT = 2'd2;

	// Register index of end_char on the configuration port.
	localparam logic REG_END_CHAR = 1'b0;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_DIGITS,
		PH_DONE
	} atoi_phase_t;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_NOT_GO,
		COND_AT_LEN,
		COND_ZERO,
		COND_IS_SEP
	} cond_t;

	typedef struct packed {
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic            act_idle;
		logic            act_read;
		logic            act_char;
		logic            act_close;
		logic            act_adv;
		logic            act_count;
	} ucode_t;

	// Program steps.
	localparam logic [PC_W-1:0] ST_IDLE  = 3'd0;
	localparam logic [PC_W-1:0] ST_FETCH = 3'd1;
	localparam logic [PC_W-1:0] ST_EXAM  = 3'd2;
	localparam logic [PC_W-1:0] ST_CLASS = 3'd3;
	localparam logic [PC_W-1:0] ST_CHAR  = 3'd4;
	localparam logic [PC_W-1:0] ST_SEP   = 3'd5;
	localparam logic [PC_W-1:0] ST_LEND  = 3'd6;
	localparam logic [PC_W-1:0] ST_FIN   = 3'd7;

	// Control store: jump to target when the condition holds, else fall through.
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{cond: COND_ALWAYS, target: ST_IDLE, default: 1'b0};
		unique case (pc)
			ST_IDLE: begin
				w.cond = COND_NOT_GO; w.target = ST_IDLE; w.act_idle = 1'b1;
			end
			ST_FETCH: begin
				w.cond = COND_AT_LEN; w.target = ST_LEND; w.act_read = 1'b1;
			end
			ST_EXAM: begin
				w.cond = COND_ZERO; w.target = ST_LEND;
			end
			ST_CLASS: begin
				w.cond = COND_IS_SEP; w.target = ST_SEP;
			end
			ST_CHAR: begin
				w.cond = COND_ALWAYS; w.target = ST_FETCH;
				w.act_char = 1'b1; w.act_adv = 1'b1;
			end
			ST_SEP: begin
				w.cond = COND_ALWAYS; w.target = ST_FETCH;
				w.act_close = 1'b1; w.act_adv = 1'b1;
			end
			ST_LEND: begin
				w.cond = COND_ALWAYS; w.target = ST_FIN; w.act_close = 1'b1;
			end
			ST_FIN: begin
				w.cond = COND_ALWAYS; w.target = ST_IDLE; w.act_count = 1'b1;
			end
			default: w = '{cond: COND_ALWAYS, target: ST_IDLE, default: 1'b0};
		endcase
		return w;
	endfunction

	function automatic logic is_sep(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || (c == CH_COMMA) || (c == CH_LPAREN) ||
			(c == CH_RPAREN) || (c == CH_SEMI);
	endfunction

	function automatic logic is_blank(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

FILE: hw/rtl/sclt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Does not import sclt_pkg; no types taken from it.
module sclt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/serial_command_line_tokenizer_unit.sv
// Serial command line tokenizer: line buffer, microcoded tokenizer and atoi datapath.
// Depends on sclt_pkg (types, control store, character classes) and sclt_ram.
//
// Received bytes are stored one per cycle, back to back, while the block is idle. A byte
// that arrives with the buffer full is dropped and the buffer restarts at position zero.
// The end character (register 0, reset ';') starts a walk of the stored line: the first
// token leaves as name bytes (tuser 0), every later token as one 16-bit atoi value
// (tuser 1), and a closing request (tuser 2, tlast high) carries the argument count, -1
// for an empty line. The walk is driven by an eight-step control program: each stored
// byte passes four steps (fetch with RAM read, test for a zero byte, classify, act), the
// line closes in the LEND and FIN steps, and the walk halts while the output is stalled;
// no byte is accepted during the walk. The line RAM needs no clearing pass after reset.
module serial_command_line_tokenizer_unit
	import sclt_pkg::*;
#(
	parameter int LINE_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// Received characters.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	// Parsed items.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] name_byte, [23:8] arg_value,
	                                    // [30:24] arg_count, [31] zero
	output logic [1:0]  m_axis_tuser,   // [1:0] item_kind
	output logic        m_axis_tlast,   // last_item
	// Configuration.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int PTR_W  = $clog2(LINE_BYTES + 1);
	localparam int ADDR_W = $clog2(LINE_BYTES);
	localparam logic [PTR_W-1:0] FULL_COUNT = PTR_W'(LINE_BYTES);

	logic [CHAR_W-1:0]  end_char_q;
	logic [PC_W-1:0]    pc_q;
	logic [PTR_W-1:0]   fill_q;
	logic [PTR_W-1:0]   ptr_q;
	logic [COUNT_W-1:0] tok_q;
	logic               in_tok_q;
	logic [ARG_W-1:0]   acc_q;
	logic               neg_q;
	atoi_phase_t        phase_q;

	logic               out_valid_q;
	logic [KIND_W-1:0]  out_kind_q;
	logic [CHAR_W-1:0]  out_name_q;
	logic [ARG_W-1:0]   out_arg_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_last_q;

	ucode_t             ucw;
	logic [CHAR_W-1:0]  cur;
	logic               accept;
	logic               full;
	logic               go;
	logic               store;
	logic               emit_req;
	logic               slot_free;
	logic               stall;
	logic               taken;
	logic               run;
	logic [ARG_W-1:0]   acc_mul;
	logic [ARG_W-1:0]   acc_step;
	logic [ARG_W-1:0]   arg_out;

	// ---------------------------------------------------------------- configuration
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_END_CHAR) begin
			prdata = {24'd0, end_char_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_char_q <= END_CHAR_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_END_CHAR)) begin
			end_char_q <= pwdata[7:0];
		end
	end

	// ---------------------------------------------------------------- line store
	sclt_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(LINE_BYTES)
	) u_line_ram (
		.clk  (clk),
		.we   (store),
		.waddr(fill_q[ADDR_W-1:0]),
		.wdata(s_axis_tdata),
		.re   (ucw.act_read),
		.raddr(ptr_q[ADDR_W-1:0]),
		.rdata(cur)
	);

	// ---------------------------------------------------------------- sequencer decode
	assign ucw           = ucode_rom(pc_q);
	assign s_axis_tready = ucw.act_idle;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign full          = (fill_q == FULL_COUNT);
	assign go            = accept && !full && (s_axis_tdata == end_char_q);
	assign store         = accept && !full && (s_axis_tdata != end_char_q);

	assign slot_free = !out_valid_q || m_axis_tready;

	always_comb begin
		emit_req = 1'b0;
		if (ucw.act_char && (tok_q == '0)) begin
			emit_req = 1'b1;
		end
		if (ucw.act_close && in_tok_q && (tok_q != '0)) begin
			emit_req = 1'b1;
		end
		if (ucw.act_count) begin
			emit_req = 1'b1;
		end
	end

	assign stall = emit_req && !slot_free;
	assign run   = !stall;

	always_comb begin
		unique case (ucw.cond)
			COND_ALWAYS: taken = 1'b1;
			COND_NOT_GO: taken = !go;
			COND_AT_LEN: taken = (ptr_q == fill_q);
			COND_ZERO:   taken = (cur == CH_NUL);
			COND_IS_SEP: taken = is_sep(cur);
			default:     taken = 1'b1;
		endcase
	end

	// ---------------------------------------------------------------- atoi datapath
	assign acc_mul  = {acc_q[ARG_W-4:0], 3'd0} + {acc_q[ARG_W-2:0], 1'b0};
	assign acc_step = acc_mul + {12'd0, cur[3:0] - CH_ZERO[3:0]};
	assign arg_out  = neg_q ? (ARG_W'(0) - acc_q) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= ST_IDLE;
			fill_q   <= '0;
			ptr_q    <= '0;
			tok_q    <= '0;
			in_tok_q <= 1'b0;
			acc_q    <= '0;
			neg_q    <= 1'b0;
			phase_q  <= PH_LEAD;
		end else if (run) begin
			pc_q <= taken ? ucw.target : pc_q + PC_W'(1);

			if (ucw.act_idle) begin
				ptr_q    <= '0;
				tok_q    <= '0;
				in_tok_q <= 1'b0;
				acc_q    <= '0;
				neg_q    <= 1'b0;
				phase_q  <= PH_LEAD;
				if (accept && full) begin
					fill_q <= '0;
				end else if (store) begin
					fill_q <= fill_q + PTR_W'(1);
				end
			end

			if (ucw.act_adv) begin
				ptr_q <= ptr_q + PTR_W'(1);
			end

			if (ucw.act_char) begin
				in_tok_q <= 1'b1;
				if (tok_q != '0) begin
					unique case (phase_q)
						PH_LEAD: begin
							if (is_blank(cur)) begin
								phase_q <= PH_LEAD;
							end else if ((cur == CH_PLUS) || (cur == CH_MINUS)) begin
								neg_q   <= (cur == CH_MINUS);
								phase_q <= PH_DIGITS;
							end else if (is_digit(cur)) begin
								acc_q   <= acc_step;
								phase_q <= PH_DIGITS;
							end else begin
								phase_q <= PH_DONE;
							end
						end
						PH_DIGITS: begin
							if (is_digit(cur)) begin
								acc_q <= acc_step;
							end else begin
								phase_q <= PH_DONE;
							end
						end
						PH_DONE: phase_q <= PH_DONE;
						default: phase_q <= PH_DONE;
					endcase
				end
			end

			// Close an open token: count it and reset the converter.
			if (ucw.act_close && in_tok_q) begin
				tok_q    <= tok_q + COUNT_W'(1);
				in_tok_q <= 1'b0;
				acc_q    <= '0;
				neg_q    <= 1'b0;
				phase_q  <= PH_LEAD;
			end

			if (ucw.act_count) begin
				fill_q <= '0;
			end
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_req && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_req && slot_free) begin
			out_kind_q  <= KIND_NAME;
			out_name_q  <= '0;
			out_arg_q   <= '0;
			out_count_q <= '0;
			out_last_q  <= 1'b0;
			if (ucw.act_char) begin
				out_name_q <= cur;
			end else if (ucw.act_close) begin
				out_kind_q <= KIND_ARG;
				out_arg_q  <= arg_out;
			end else begin
				out_kind_q  <= KIND_COUNT;
				out_count_q <= tok_q - COUNT_W'(1);
				out_last_q  <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_count_q, out_arg_q, out_name_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

endmodule
